@@ sv/prq_pkg.sv @@
// shared types and constants of the polyline ribbon quad extruder
package prq_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RegW    = 31;
  localparam int unsigned TexW    = 16;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned RootW   = SumW / 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_WIDTH = 1'b0,
    REG_REPEAT_LEN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     end_of_trail;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vert_x;
    logic signed [CoordW-1:0] vert_y;
    logic signed [CoordW-1:0] vert_z;
    logic                     tex_u;
    logic [TexW-1:0]          tex_v;
    logic [IdxW-1:0]          vert_index;
    logic                     mesh_end;
    logic                     degenerate;
    logic                     last_of_run;
  } result_t;

endpackage

@@ sv/polyline_ribbon_quads.sv @@
// top level: trail points in, ribbon quad vertices and mesh markers out
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one trail point per
// item; in_ready_o is high only while the sequencer is idle. Output channel
// (out_valid_o/out_ready_i/out_data_o) gives zero, one, four or five result
// items per point; the final one carries last_of_run. Register writes come on
// cfg_valid_i/cfg_index_i/cfg_data_i, always ready; the user is to make them
// only while idle, which the block itself does not enforce. A first point of
// a segment, and a zero point on an empty mesh, are handled in the accept
// cycle. A zero point closing a mesh gives its marker from state S_MARK once
// the output register is free. A later point runs five serial 33x33
// multiplies, two serial square roots and three serial divides on the
// bit-serial arithmetic units, then emits four output items; a repeated
// point in xz skips two multiplies and two divides. The output register
// holds a result while the receiver stalls; the sequencer waits on it, and
// the next point is taken while the last result of a point is still waiting.
// Reset clears the mesh state and loads a half width of 2.0 and a repeat
// length of 7.0.
module polyline_ribbon_quads (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  prq_pkg::point_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output prq_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [prq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [prq_pkg::RegW-1:0]     cfg_data_i
);

  import prq_pkg::*;

  localparam int unsigned EW = CoordW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MXX, S_MZZ, S_MYY, S_SQ3, S_SQXZ, S_DIVV,
    S_MZH, S_DVZ, S_MXH, S_DVX, S_EDGE, S_EMIT, S_MARK
  } state_e;

  state_e state_q;

  logic [RegW-1:0]   hw_q, trl_q;
  logic [CoordW-1:0] cx_q, cy_q, cz_q;
  logic              eot_q;
  logic [CoordW-1:0] px_q, py_q, pz_q;
  logic [CoordW-1:0] efx_q, efy_q, efz_q, esx_q, esy_q, esz_q;
  logic [CoordW-1:0] nfx_q, nfz_q, nsx_q, nsz_q;
  logic [DiffW-1:0]  mx_q, my_q, mz_q;
  logic              sx_q, sz_q;
  logic [SumW-1:0]   sxz_q, s3_q;
  logic [RootW-1:0]  d3_q, nxz_q;
  logic [TexW-1:0]   v_q;
  logic [CoordW-1:0] qz_q, qx_q;
  logic              deg_q;
  logic [IdxW-1:0]   vcnt_q;
  logic              have_prev_q, nonempty_q;
  logic [1:0]        k_q;
  logic              run_q;
  result_t           out_q;
  logic              out_valid_q;

  logic              out_free, out_load, in_acc, in_zero;
  logic              mul_start, sqrt_start, div_start;
  logic              mul_done, sqrt_done, div_done;
  logic [DiffW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0]  mul_p;
  logic [SumW-1:0]   sqrt_x;
  logic [RootW-1:0]  sqrt_r;
  logic [ProdW-1:0]  div_n, div_q;
  logic [RootW-1:0]  div_d;
  logic [DiffW-1:0]  dx, dy, dz;
  logic [EW-1:0]     offz, offx;
  logic [TexW-1:0]   v_sat;

  function automatic logic [EW-1:0] sext_c(input logic [CoordW-1:0] a);
    sext_c = {{2{a[CoordW-1]}}, a};
  endfunction

  function automatic logic [CoordW-1:0] sat_c(input logic [EW-1:0] v);
    logic [CoordW-1:0] r;
    if (v[EW-1:CoordW-1] == '0 || v[EW-1:CoordW-1] == '1) begin
      r = v[CoordW-1:0];
    end else if (v[EW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    sat_c = r;
  endfunction

  function automatic logic [EW-1:0] soff(input logic [CoordW-1:0] q, input logic neg);
    logic [EW-1:0] m;
    m = {2'b00, q};
    soff = neg ? (~m + 1'b1) : m;
  endfunction

  function automatic result_t vtx(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                  input logic [CoordW-1:0] z, input logic u,
                                  input logic [TexW-1:0] v, input logic [IdxW-1:0] idx,
                                  input logic deg, input logic last);
    result_t r;
    r.vert_x      = x;
    r.vert_y      = y;
    r.vert_z      = z;
    r.tex_u       = u;
    r.tex_v       = v;
    r.vert_index  = idx;
    r.mesh_end    = 1'b0;
    r.degenerate  = deg;
    r.last_of_run = last;
    vtx = r;
  endfunction

  function automatic result_t marker();
    result_t r;
    r             = '0;
    r.mesh_end    = 1'b1;
    r.last_of_run = 1'b1;
    marker = r;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = out_free && (state_q inside {S_EMIT, S_MARK});
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign in_zero     = (in_data_i.point_x == '0) && (in_data_i.point_y == '0) &&
                       (in_data_i.point_z == '0);
  assign cfg_ready_o = 1'b1;

  // step from the current point back to the previous one
  assign dx = {px_q[CoordW-1], px_q} - {cx_q[CoordW-1], cx_q};
  assign dy = {py_q[CoordW-1], py_q} - {cy_q[CoordW-1], cy_q};
  assign dz = {pz_q[CoordW-1], pz_q} - {cz_q[CoordW-1], cz_q};

  assign offz = soff(qz_q, sz_q);
  assign offx = soff(qx_q, sx_q);

  always_comb begin
    if (div_q[ProdW-1:TexW] != '0) begin
      v_sat = '1;
    end else if (div_q[TexW-1:0] == '0) begin
      v_sat = TexW'(1);
    end else begin
      v_sat = div_q[TexW-1:0];
    end
  end

  always_comb begin
    mul_a = mx_q;
    mul_b = mx_q;
    case (state_q)
      S_MZZ:   begin mul_a = mz_q; mul_b = mz_q; end
      S_MYY:   begin mul_a = my_q; mul_b = my_q; end
      S_MZH:   begin mul_a = mz_q; mul_b = DiffW'(hw_q); end
      S_MXH:   begin mul_a = mx_q; mul_b = DiffW'(hw_q); end
      default: begin mul_a = mx_q; mul_b = mx_q; end
    endcase
  end

  assign sqrt_x = (state_q == S_SQ3) ? s3_q : sxz_q;
  assign div_n  = (state_q == S_DIVV) ? ProdW'(d3_q) : mul_p;
  assign div_d  = (state_q == S_DIVV) ? RootW'(trl_q) : nxz_q;

  assign mul_start  = !run_q && (state_q inside {S_MXX, S_MZZ, S_MYY, S_MZH, S_MXH});
  assign sqrt_start = !run_q && (state_q inside {S_SQ3, S_SQXZ});
  assign div_start  = !run_q && (state_q inside {S_DIVV, S_DVZ, S_DVX});

  prq_mul #(.AW(DiffW), .BW(DiffW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  prq_sqrt #(.XW(SumW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .x_i(sqrt_x),
    .done_o(sqrt_done), .root_o(sqrt_r)
  );

  prq_div #(.NW(ProdW), .DW(RootW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .done_o(div_done), .q_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= RegW'(131072);
      trl_q       <= RegW'(458752);
      cx_q <= '0; cy_q <= '0; cz_q <= '0; eot_q <= 1'b0;
      px_q <= '0; py_q <= '0; pz_q <= '0;
      efx_q <= '0; efy_q <= '0; efz_q <= '0;
      esx_q <= '0; esy_q <= '0; esz_q <= '0;
      nfx_q <= '0; nfz_q <= '0; nsx_q <= '0; nsz_q <= '0;
      mx_q <= '0; my_q <= '0; mz_q <= '0; sx_q <= 1'b0; sz_q <= 1'b0;
      sxz_q <= '0; s3_q <= '0; d3_q <= '0; nxz_q <= '0;
      v_q <= '0; qz_q <= '0; qx_q <= '0; deg_q <= 1'b0;
      vcnt_q      <= '0;
      have_prev_q <= 1'b0;
      nonempty_q  <= 1'b0;
      k_q         <= '0;
      run_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_HALF_WIDTH: hw_q  <= cfg_data_i;
          REG_REPEAT_LEN: trl_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (mul_start || sqrt_start || div_start) begin
        run_q <= 1'b1;
      end else if (mul_done || sqrt_done || div_done) begin
        run_q <= 1'b0;
      end

      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_zero) begin
              if (nonempty_q) begin
                state_q <= S_MARK;
              end else if (in_data_i.end_of_trail) begin
                vcnt_q      <= '0;
                have_prev_q <= 1'b0;
              end
            end else if (!have_prev_q) begin
              // first point of a segment: edges straddle it in x
              efx_q <= sat_c(sext_c(in_data_i.point_x) - EW'(hw_q));
              esx_q <= sat_c(sext_c(in_data_i.point_x) + EW'(hw_q));
              efy_q <= in_data_i.point_y;
              esy_q <= in_data_i.point_y;
              efz_q <= in_data_i.point_z;
              esz_q <= in_data_i.point_z;
              px_q  <= in_data_i.point_x;
              py_q  <= in_data_i.point_y;
              pz_q  <= in_data_i.point_z;
              have_prev_q <= !in_data_i.end_of_trail;
              if (in_data_i.end_of_trail) begin
                vcnt_q <= '0;
              end
            end else begin
              cx_q    <= in_data_i.point_x;
              cy_q    <= in_data_i.point_y;
              cz_q    <= in_data_i.point_z;
              eot_q   <= in_data_i.end_of_trail;
              state_q <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          mx_q    <= dx[DiffW-1] ? (~dx + 1'b1) : dx;
          my_q    <= dy[DiffW-1] ? (~dy + 1'b1) : dy;
          mz_q    <= dz[DiffW-1] ? (~dz + 1'b1) : dz;
          sx_q    <= dx[DiffW-1];
          sz_q    <= dz[DiffW-1];
          state_q <= S_MXX;
        end
        S_MXX: if (mul_done) begin
          sxz_q   <= SumW'(mul_p);
          state_q <= S_MZZ;
        end
        S_MZZ: if (mul_done) begin
          sxz_q   <= sxz_q + SumW'(mul_p);
          state_q <= S_MYY;
        end
        S_MYY: if (mul_done) begin
          s3_q    <= sxz_q + SumW'(mul_p);
          state_q <= S_SQ3;
        end
        S_SQ3: if (sqrt_done) begin
          d3_q    <= sqrt_r;
          state_q <= S_SQXZ;
        end
        S_SQXZ: if (sqrt_done) begin
          nxz_q   <= sqrt_r;
          state_q <= S_DIVV;
        end
        S_DIVV: if (div_done) begin
          v_q <= v_sat;
          if (nxz_q == '0) begin
            // repeated point in xz: new edges collapse onto it
            deg_q   <= 1'b1;
            qz_q    <= '0;
            qx_q    <= '0;
            state_q <= S_EDGE;
          end else begin
            deg_q   <= 1'b0;
            state_q <= S_MZH;
          end
        end
        S_MZH: if (mul_done) begin
          state_q <= S_DVZ;
        end
        S_DVZ: if (div_done) begin
          qz_q    <= div_q[CoordW-1:0];
          state_q <= S_MXH;
        end
        S_MXH: if (mul_done) begin
          state_q <= S_DVX;
        end
        S_DVX: if (div_done) begin
          qx_q    <= div_q[CoordW-1:0];
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          nfx_q   <= sat_c(sext_c(cx_q) - offz);
          nfz_q   <= sat_c(sext_c(cz_q) + offx);
          nsx_q   <= sat_c(sext_c(cx_q) + offz);
          nsz_q   <= sat_c(sext_c(cz_q) - offx);
          k_q     <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: if (out_free) begin
          out_valid_q <= 1'b1;
          k_q         <= k_q + 1'b1;
          case (k_q)
            2'd0: out_q <= vtx(efx_q, efy_q, efz_q, 1'b0, '0, vcnt_q, deg_q, 1'b0);
            2'd1: out_q <= vtx(esx_q, esy_q, esz_q, 1'b1, '0, vcnt_q + IdxW'(1),
                               deg_q, 1'b0);
            2'd2: out_q <= vtx(nsx_q, cy_q, nsz_q, 1'b1, v_q, vcnt_q + IdxW'(2),
                               deg_q, 1'b0);
            default: begin
              out_q <= vtx(nfx_q, cy_q, nfz_q, 1'b0, v_q, vcnt_q + IdxW'(3),
                           deg_q, !eot_q);
              efx_q <= nfx_q; efy_q <= cy_q; efz_q <= nfz_q;
              esx_q <= nsx_q; esy_q <= cy_q; esz_q <= nsz_q;
              px_q  <= cx_q;  py_q  <= cy_q; pz_q  <= cz_q;
              vcnt_q     <= vcnt_q + IdxW'(4);
              nonempty_q <= 1'b1;
              state_q    <= eot_q ? S_MARK : S_IDLE;
            end
          endcase
        end
        S_MARK: if (out_free) begin
          out_valid_q <= 1'b1;
          out_q       <= marker();
          vcnt_q      <= '0;
          have_prev_q <= 1'b0;
          nonempty_q  <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an open mesh always keeps a previous point
  a_nonempty_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_q |-> have_prev_q)
    else $error("mesh open without a previous point");

  // vertices are emitted only in whole quads
  a_quad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q[1:0] == 2'b00)
    else $error("vertex count not a multiple of four");

  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mesh_end |->
      out_data_o.vert_index == '0 && out_data_o.tex_v == '0 && out_data_o.last_of_run)
    else $error("marker item carries vertex data");

  // arithmetic units finish only for an operation that was started
  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done || sqrt_done || div_done) |-> run_q)
    else $error("unit done without a running operation");

endmodule

@@ sv/prq_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module prq_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q;
  logic [AW-1:0]    a_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [AW:0]      sum;

  // add the multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{AW{1'b0}}, b_i};
      a_q   <= a_i;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ sv/prq_sqrt.sv @@
// serial integer square root, two radicand bits per cycle
module prq_sqrt #(
  parameter int unsigned XW = 68
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [XW-1:0]   x_i,
  output logic            done_o,
  output logic [XW/2-1:0] root_o
);

  localparam int unsigned RW   = XW / 2;
  localparam int unsigned CntW = $clog2(RW + 1);

  logic [XW-1:0]   x_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  assign rem_sh = {rem_q[RW-1:0], x_q[XW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[XW-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ sv/prq_div.sv @@
// serial restoring divider, one quotient bit per cycle
module prq_div #(
  parameter int unsigned NW = 66,
  parameter int unsigned DW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [NW-1:0] q_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   n_q;
  logic [NW-1:0]   q_q;
  logic [DW-1:0]   d_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem_q, n_q[NW-1]};
  assign diff   = rem_sh - {1'b0, d_q};
  assign ge     = (rem_sh >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // a zero divisor gives an all-ones quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], 1'b0};
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule
